### hw/rtl/fra_pkg.sv
// Shared operation codes and result field widths for the fraction arithmetic block.
package fra_pkg;

    typedef logic [1:0] op_t;

    localparam op_t OP_ADD = 2'd0;
    localparam op_t OP_SUB = 2'd1;
    localparam op_t OP_MUL = 2'd2;
    localparam op_t OP_DIV = 2'd3;

    localparam int WHOLE_W = 33;
    localparam int FRAC_W  = 31;
    localparam int OUT_TW  = WHOLE_W + 1 + FRAC_W + FRAC_W;

endpackage

### hw/rtl/fraction_arith_reduce_top.sv
// Top level of the exact fraction arithmetic unit with gcd reduction of the result.
//
// Usage: one input transaction carries an operation in s_tuser and two signed fractions
// in s_tdata. The block adds, subtracts, multiplies or divides them exactly and returns
// one result transaction: a mixed number whose whole part is the truncating quotient and
// whose fraction is reduced by the gcd, with the error status in m_tuser.
// All arithmetic runs on one shared adder under a small sequencer. Each product takes
// a set-up step, OPERAND_WIDTH shift-and-add steps and a hand-off step. Each division
// or modulo is a restoring division of 2*OPERAND_WIDTH+1 steps plus a hand-off step.
// Add and subtract need three products, multiply and divide two. A zero remainder
// needs one division; otherwise there are three plus one per Euclid step, and the
// number of Euclid modulo steps depends on the data. An error item skips the
// arithmetic and goes straight to the output step.
// s_tready is high only while the sequencer is idle; one item is worked on at a time.
// A finished result sits in an output register until the receiver takes it, and the
// next item can already be accepted and computed meanwhile; a stalled receiver only
// holds the sequencer at its final step. A synchronous low aresetn drops the output
// valid flag and returns the sequencer to idle.
module fraction_arith_reduce_top #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // num_a, den_a, num_b, den_b from the lowest bit up, zero padded to bytes
    input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]   s_tdata,
    // op
    input  logic [1:0]                              s_tuser,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // whole_part, negative_zero, frac_num, frac_den from the lowest bit up
    output logic [fra_pkg::OUT_TW-1:0]              m_tdata,
    // status
    output logic                                    m_tuser
);

    localparam int W  = OPERAND_WIDTH;
    localparam int MW = 2*W + 1;
    localparam int AW = MW + 1;
    localparam int CW = $clog2(MW + 1);
    localparam int XW = (MW > fra_pkg::WHOLE_W) ? MW : fra_pkg::WHOLE_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MSET  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_COMB  = 3'd3;
    localparam logic [2:0] S_COMB2 = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    localparam logic [1:0] J_QR  = 2'd0;
    localparam logic [1:0] J_GCD = 2'd1;
    localparam logic [1:0] J_RN  = 2'd2;
    localparam logic [1:0] J_DN  = 2'd3;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0]    idx_reg, idx_next;
    logic [1:0]    job_reg, job_next;
    logic          err_reg, err_next;
    fra_pkg::op_t  op_reg, op_next;
    logic          sna_reg, sda_reg, snb_reg, sdb_reg;
    logic          sna_next, sda_next, snb_next, sdb_next;
    logic [W-1:0]  na_reg, da_reg, nb_reg, db_reg;
    logic [W-1:0]  na_next, da_next, nb_next, db_next;
    logic [MW-1:0] mc_reg, mc_next, acc_reg, acc_next;
    logic [W-1:0]  mp_reg, mp_next;
    logic [MW-1:0] t1_reg, t1_next, t2_reg, t2_next, den_reg, den_next;
    logic          num_neg_reg, num_neg_next;
    logic [MW-1:0] rem_reg, rem_next, quo_reg, quo_next, dvs_reg, dvs_next;
    logic [MW-1:0] q_reg, q_next, r_reg, r_next, gb_reg, gb_next;
    logic [MW-1:0] fnum_reg, fnum_next, fden_reg, fden_next;

    logic                       m_valid_reg, m_valid_next;
    logic                       m_status_reg, m_status_next;
    logic [fra_pkg::WHOLE_W-1:0] m_whole_reg, m_whole_next;
    logic                       m_nz_reg, m_nz_next;
    logic [fra_pkg::FRAC_W-1:0] m_fn_reg, m_fn_next, m_fd_reg, m_fd_next;

    // shared adder
    logic [AW-1:0] au_x, au_y;
    logic          au_c;
    logic [AW:0]   au_sum;
    assign au_sum = {1'b0, au_x} + {1'b0, au_y} + {{AW{1'b0}}, au_c};

    logic [W-1:0]  in_na, in_da, in_nb, in_db;
    logic [W-1:0]  mul_a, mul_b;
    logic          t1_neg, t2_neg, den_neg, wneg;
    logic [XW-1:0] q_ext, whole_ext;
    logic          in_acc;

    assign in_na = s_tdata[0*W +: W];
    assign in_da = s_tdata[1*W +: W];
    assign in_nb = s_tdata[2*W +: W];
    assign in_db = s_tdata[3*W +: W];

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    assign t1_neg  = sna_reg ^ ((op_reg == fra_pkg::OP_MUL) ? snb_reg : sdb_reg);
    assign t2_neg  = snb_reg ^ sda_reg ^ (op_reg == fra_pkg::OP_SUB);
    assign den_neg = (op_reg == fra_pkg::OP_DIV) ? (snb_reg ^ sda_reg) : (sda_reg ^ sdb_reg);
    assign wneg    = num_neg_reg != den_neg;

    assign q_ext     = XW'(q_reg);
    assign whole_ext = (wneg && (q_reg != '0)) ? (XW'(0) - q_ext) : q_ext;

    always_comb begin
        unique case (idx_reg)
            2'd0: begin
                mul_a = na_reg;
                mul_b = (op_reg == fra_pkg::OP_MUL) ? nb_reg : db_reg;
            end
            2'd1: begin
                mul_a = nb_reg;
                mul_b = da_reg;
            end
            default: begin
                mul_a = (op_reg == fra_pkg::OP_DIV) ? nb_reg : da_reg;
                mul_b = (op_reg == fra_pkg::OP_DIV) ? da_reg : db_reg;
            end
        endcase
    end

    always_comb begin
        au_x = '0;
        au_y = '0;
        au_c = 1'b0;
        unique case (state_reg)
            S_MUL: begin
                au_x = {1'b0, acc_reg};
                au_y = mp_reg[0] ? {1'b0, mc_reg} : '0;
            end
            S_COMB: begin
                au_x = {1'b0, t1_reg};
                if (t1_neg == t2_neg) begin
                    au_y = {1'b0, t2_reg};
                end else begin
                    au_y = ~{1'b0, t2_reg};
                    au_c = 1'b1;
                end
            end
            S_COMB2: begin
                au_x = {1'b0, t2_reg};
                au_y = ~{1'b0, t1_reg};
                au_c = 1'b1;
            end
            S_DIV: begin
                au_x = {rem_reg, quo_reg[MW-1]};
                au_y = ~{1'b0, dvs_reg};
                au_c = 1'b1;
            end
            default: begin
                au_x = '0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;   cnt_next = cnt_reg;     idx_next = idx_reg;
        job_next = job_reg;       err_next = err_reg;     op_next = op_reg;
        sna_next = sna_reg;       sda_next = sda_reg;     snb_next = snb_reg;
        sdb_next = sdb_reg;       na_next = na_reg;       da_next = da_reg;
        nb_next = nb_reg;         db_next = db_reg;       mc_next = mc_reg;
        acc_next = acc_reg;       mp_next = mp_reg;       t1_next = t1_reg;
        t2_next = t2_reg;         den_next = den_reg;     num_neg_next = num_neg_reg;
        rem_next = rem_reg;       quo_next = quo_reg;     dvs_next = dvs_reg;
        q_next = q_reg;           r_next = r_reg;         gb_next = gb_reg;
        fnum_next = fnum_reg;     fden_next = fden_reg;
        m_valid_next = m_valid_reg;  m_status_next = m_status_reg;
        m_whole_next = m_whole_reg;  m_nz_next = m_nz_reg;
        m_fn_next = m_fn_reg;        m_fd_next = m_fd_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    op_next  = s_tuser;
                    sna_next = in_na[W-1];
                    sda_next = in_da[W-1];
                    snb_next = in_nb[W-1];
                    sdb_next = in_db[W-1];
                    na_next  = in_na[W-1] ? (W'(0) - in_na) : in_na;
                    da_next  = in_da[W-1] ? (W'(0) - in_da) : in_da;
                    nb_next  = in_nb[W-1] ? (W'(0) - in_nb) : in_nb;
                    db_next  = in_db[W-1] ? (W'(0) - in_db) : in_db;
                    err_next = (in_da == '0) || (in_db == '0) ||
                               ((s_tuser == fra_pkg::OP_DIV) &&
                                ((in_na == '0) || (in_nb == '0)));
                    idx_next   = 2'd0;
                    state_next = err_next ? S_DONE : S_MSET;
                end
            end
            S_MSET: begin
                mc_next    = MW'(mul_a);
                mp_next    = mul_b;
                acc_next   = '0;
                cnt_next   = CW'(W);
                state_next = S_MUL;
            end
            S_MUL: begin
                if (cnt_reg != '0) begin
                    acc_next = au_sum[MW-1:0];
                    mc_next  = {mc_reg[MW-2:0], 1'b0};
                    mp_next  = {1'b0, mp_reg[W-1:1]};
                    cnt_next = cnt_reg - 1'b1;
                end else begin
                    unique case (idx_reg)
                        2'd0: begin
                            t1_next    = acc_reg;
                            idx_next   = ((op_reg == fra_pkg::OP_ADD) ||
                                          (op_reg == fra_pkg::OP_SUB)) ? 2'd1 : 2'd2;
                            state_next = S_MSET;
                        end
                        2'd1: begin
                            t2_next    = acc_reg;
                            idx_next   = 2'd2;
                            state_next = S_MSET;
                        end
                        default: begin
                            den_next   = acc_reg;
                            state_next = S_COMB;
                        end
                    endcase
                end
            end
            S_COMB: begin
                if ((op_reg == fra_pkg::OP_MUL) || (op_reg == fra_pkg::OP_DIV)) begin
                    num_neg_next = t1_neg;
                    quo_next     = t1_reg;
                    state_next   = S_DIV;
                end else if ((t1_neg == t2_neg) || au_sum[AW]) begin
                    num_neg_next = t1_neg;
                    quo_next     = au_sum[MW-1:0];
                    state_next   = S_DIV;
                end else begin
                    state_next = S_COMB2;
                end
                rem_next = '0;
                dvs_next = den_reg;
                cnt_next = CW'(MW);
                job_next = J_QR;
            end
            S_COMB2: begin
                num_neg_next = t2_neg;
                quo_next     = au_sum[MW-1:0];
                rem_next     = '0;
                dvs_next     = den_reg;
                cnt_next     = CW'(MW);
                job_next     = J_QR;
                state_next   = S_DIV;
            end
            S_DIV: begin
                if (cnt_reg != '0) begin
                    if (au_sum[AW]) begin
                        rem_next = au_sum[MW-1:0];
                        quo_next = {quo_reg[MW-2:0], 1'b1};
                    end else begin
                        rem_next = {rem_reg[MW-2:0], quo_reg[MW-1]};
                        quo_next = {quo_reg[MW-2:0], 1'b0};
                    end
                    cnt_next = cnt_reg - 1'b1;
                end else begin
                    // Every follow-on job starts a fresh division.
                    rem_next = '0;
                    cnt_next = CW'(MW);
                    unique case (job_reg)
                        J_QR: begin
                            q_next = quo_reg;
                            r_next = rem_reg;
                            if (rem_reg == '0) begin
                                state_next = S_DONE;
                            end else begin
                                quo_next = den_reg;
                                dvs_next = rem_reg;
                                gb_next  = rem_reg;
                                job_next = J_GCD;
                            end
                        end
                        J_GCD: begin
                            if (rem_reg == '0) begin
                                quo_next = r_reg;
                                dvs_next = gb_reg;
                                job_next = J_RN;
                            end else begin
                                quo_next = gb_reg;
                                dvs_next = rem_reg;
                                gb_next  = rem_reg;
                            end
                        end
                        J_RN: begin
                            fnum_next = quo_reg;
                            quo_next  = den_reg;
                            dvs_next  = gb_reg;
                            job_next  = J_DN;
                        end
                        default: begin
                            fden_next  = quo_reg;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                    if (err_reg) begin
                        m_status_next = 1'b1;
                        m_whole_next  = '0;
                        m_nz_next     = 1'b0;
                        m_fn_next     = '0;
                        m_fd_next     = '0;
                    end else begin
                        m_status_next = 1'b0;
                        m_whole_next  = whole_ext[fra_pkg::WHOLE_W-1:0];
                        m_nz_next     = (q_reg == '0) && (r_reg != '0) && wneg;
                        if (r_reg == '0) begin
                            m_fn_next = '0;
                            m_fd_next = {{(fra_pkg::FRAC_W-1){1'b0}}, 1'b1};
                        end else begin
                            m_fn_next = fnum_reg[fra_pkg::FRAC_W-1:0];
                            m_fd_next = fden_reg[fra_pkg::FRAC_W-1:0];
                        end
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;   idx_reg <= idx_next;   job_reg <= job_next;
        err_reg <= err_next;   op_reg <= op_next;
        sna_reg <= sna_next;   sda_reg <= sda_next;
        snb_reg <= snb_next;   sdb_reg <= sdb_next;
        na_reg <= na_next;     da_reg <= da_next;
        nb_reg <= nb_next;     db_reg <= db_next;
        mc_reg <= mc_next;     acc_reg <= acc_next;   mp_reg <= mp_next;
        t1_reg <= t1_next;     t2_reg <= t2_next;     den_reg <= den_next;
        num_neg_reg <= num_neg_next;
        rem_reg <= rem_next;   quo_reg <= quo_next;   dvs_reg <= dvs_next;
        q_reg <= q_next;       r_reg <= r_next;       gb_reg <= gb_next;
        fnum_reg <= fnum_next; fden_reg <= fden_next;
        m_status_reg <= m_status_next;
        m_whole_reg  <= m_whole_next;
        m_nz_reg     <= m_nz_next;
        m_fn_reg     <= m_fn_next;
        m_fd_reg     <= m_fd_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {m_fd_reg, m_fn_reg, m_nz_reg, m_whole_reg};

`ifndef SYNTH
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg) |-> ((m_whole_reg == '0) && (m_fd_reg == '0)))
        else $error("error result carries a nonzero payload");
    a_den_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_status_reg) |-> (m_fd_reg != '0))
        else $error("valid result with zero denominator");
    a_nz_whole: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_nz_reg) |-> ((m_whole_reg == '0) && (m_fn_reg != '0)))
        else $error("negative zero flag with nonzero whole part");
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_tready)
        else $error("ready again straight after an accepted transaction");
`endif

endmodule
